// ----- design/bevq_pkg.sv -----
`timescale 1ns / 1ps
// bevq_pkg: shared types, codes and reset values for the button event qualifier
// no dependencies

package bevq_pkg;

    // field widths
    localparam int TIME_W  = 16;
    localparam int PIN_W   = 3;
    localparam int CODE_W  = 3;
    localparam int CFG_IDX_W = 2;
    localparam int LANES   = 2;

    // request kinds
    localparam logic OP_PIN_CHANGE = 1'b0;
    localparam logic OP_POLL       = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HELD_DELAY = 2'd2;

    // configuration reset values
    localparam logic [TIME_W-1:0] DEBOUNCE_RST   = 16'd120;
    localparam logic [TIME_W-1:0] LONG_PRESS_RST = 16'd950;
    localparam logic [TIME_W-1:0] HELD_DELAY_RST = 16'd500;

    // pin positions in changed_mask and pin_levels
    localparam logic [1:0] PIN_CCW  = 2'd0;
    localparam logic [1:0] PIN_CW   = 2'd1;
    localparam logic [1:0] PIN_PUSH = 2'd2;

    // event codes
    localparam logic [CODE_W-1:0] EV_NONE     = 3'd0;
    localparam logic [CODE_W-1:0] EV_PUSH     = 3'd1;
    localparam logic [CODE_W-1:0] EV_CW       = 3'd2;
    localparam logic [CODE_W-1:0] EV_CCW      = 3'd3;
    localparam logic [CODE_W-1:0] EV_CW_HELD  = 3'd4;
    localparam logic [CODE_W-1:0] EV_CCW_HELD = 3'd5;

    // lane 0 is the clockwise switch, lane 1 the counter-clockwise one
    localparam logic [1:0] LANE_PIN [LANES] = '{PIN_CW, PIN_CCW};
    localparam logic [CODE_W-1:0] LANE_EDGE_EV [LANES] = '{EV_CW, EV_CCW};
    localparam logic [CODE_W-1:0] LANE_HELD_EV [LANES] = '{EV_CW_HELD, EV_CCW_HELD};

    typedef struct packed {
        logic              opcode;
        logic [TIME_W-1:0] now_ms;
        logic [PIN_W-1:0]  changed_mask;
        logic [PIN_W-1:0]  pin_levels;
    } item_t;

    typedef struct packed {
        logic [CODE_W-1:0] event_code;
        logic              is_pressed;
        logic              is_long_press;
    } result_t;

    // handshake between the core and the result register
    typedef struct packed {
        logic load;   // core finished a poll, result is to be captured
        logic ready;  // result register can take a result this cycle
    } out_ctl_t;

endpackage

// ----- design/bevq_in_reg.sv -----
`timescale 1ns / 1ps
// bevq_in_reg: input register holding one request ahead of the core
// depends on bevq_pkg

module bevq_in_reg
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  bevq_pkg::item_t in_item,
    input  logic           advance,
    output logic           item_valid,
    output bevq_pkg::item_t item
);

    logic            valid_reg;
    logic            valid_next;
    bevq_pkg::item_t item_reg;
    logic            take;

    // stall only while a held request cannot move on
    assign in_stall   = valid_reg && !advance;
    assign take       = in_valid && !in_stall;
    assign valid_next = take || (valid_reg && !advance);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// ----- design/bevq_core.sv -----
`timescale 1ns / 1ps
// bevq_core: configuration registers, button state and the per-request update
// depends on bevq_pkg

module bevq_core
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [bevq_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [bevq_pkg::TIME_W-1:0]         cfg_data,
    input  logic                                item_valid,
    input  bevq_pkg::item_t                     item,
    input  logic                                out_ready,
    output logic                                advance,
    output bevq_pkg::out_ctl_t                  out_ctl,
    output bevq_pkg::result_t                   result
);

    localparam int L  = bevq_pkg::LANES;
    localparam int TW = bevq_pkg::TIME_W;

    // configuration
    logic [TW-1:0] debounce_reg;
    logic [TW-1:0] long_press_reg;
    logic [TW-1:0] held_delay_reg;

    // rotary lanes
    logic [L-1:0]  edge_pending_reg;
    logic [L-1:0]  edge_pending_next;
    logic [L-1:0]  held_now_reg;
    logic [L-1:0]  held_now_next;
    logic [L-1:0]  held_reported_reg;
    logic [L-1:0]  held_reported_next;
    logic [TW-1:0] last_press_reg [L];
    logic [TW-1:0] last_press_next [L];
    logic [TW-1:0] hold_start_reg [L];
    logic [TW-1:0] hold_start_next [L];

    // push button
    logic          push_down_reg;
    logic          push_down_next;
    logic [TW-1:0] push_start_reg;
    logic [TW-1:0] push_start_next;
    logic          push_short_reg;
    logic          push_short_next;
    logic          push_long_reg;
    logic          push_long_next;

    logic          is_poll;
    logic          push_pressed;
    logic [TW-1:0] push_elapsed;
    logic [TW-1:0] press_elapsed [L];
    logic [TW-1:0] hold_elapsed [L];
    logic          done;
    logic          hr_now;

    assign is_poll = (item.opcode == bevq_pkg::OP_POLL);
    // pin changes never wait for the result side
    assign advance = item_valid && (!is_poll || out_ready);
    assign out_ctl.load  = advance && is_poll;
    assign out_ctl.ready = out_ready;

    assign push_pressed = !item.pin_levels[bevq_pkg::PIN_PUSH];
    assign push_elapsed = item.now_ms - push_start_reg;

    always_comb
    begin
        edge_pending_next  = edge_pending_reg;
        held_now_next      = held_now_reg;
        held_reported_next = held_reported_reg;
        last_press_next    = last_press_reg;
        hold_start_next    = hold_start_reg;
        push_down_next     = push_down_reg;
        push_start_next    = push_start_reg;
        push_short_next    = push_short_reg;
        push_long_next     = push_long_reg;
        result.event_code    = bevq_pkg::EV_NONE;
        result.is_pressed    = 1'b0;
        result.is_long_press = 1'b0;
        done   = 1'b0;
        hr_now = 1'b0;
        for (int k = 0; k < L; k++)
        begin
            press_elapsed[k] = item.now_ms - last_press_reg[k];
            hold_elapsed[k]  = item.now_ms - hold_start_reg[k];
        end

        if (!is_poll)
        begin
            for (int k = 0; k < L; k++)
            begin
                if (item.changed_mask[bevq_pkg::LANE_PIN[k]])
                begin
                    if (!item.pin_levels[bevq_pkg::LANE_PIN[k]])
                    begin
                        if (press_elapsed[k] > debounce_reg)
                        begin
                            edge_pending_next[k] = 1'b1;
                            last_press_next[k]   = item.now_ms;
                        end
                        held_now_next[k] = 1'b1;
                    end
                    else
                    begin
                        held_now_next[k] = 1'b0;
                    end
                end
            end
            if (item.changed_mask[bevq_pkg::PIN_PUSH])
            begin
                if (push_pressed && !push_down_reg)
                begin
                    push_down_next  = 1'b1;
                    push_start_next = item.now_ms;
                end
                else if (!push_pressed && push_down_reg)
                begin
                    push_down_next = 1'b0;
                    if (push_elapsed < long_press_reg)
                    begin
                        push_short_next = 1'b1;
                    end
                    else
                    begin
                        push_long_next = 1'b1;
                    end
                end
            end
        end
        else if (push_short_reg || push_long_reg)
        begin
            result.event_code    = bevq_pkg::EV_PUSH;
            result.is_pressed    = 1'b1;
            result.is_long_press = push_long_reg;
            push_short_next = 1'b0;
            push_long_next  = 1'b0;
        end
        else
        begin
            // clockwise lane first, counter-clockwise only if it stayed quiet
            for (int k = 0; k < L; k++)
            begin
                if (!done)
                begin
                    if (edge_pending_reg[k])
                    begin
                        edge_pending_next[k] = 1'b0;
                        result.event_code = bevq_pkg::LANE_EDGE_EV[k];
                        result.is_pressed = 1'b1;
                        if (held_now_reg[k])
                        begin
                            hold_start_next[k] = item.now_ms;
                        end
                        done = 1'b1;
                    end
                    else if (held_now_reg[k])
                    begin
                        hr_now = held_reported_reg[k] || (hold_elapsed[k] >= held_delay_reg);
                        held_reported_next[k] = hr_now;
                        if (hr_now)
                        begin
                            result.event_code = bevq_pkg::LANE_HELD_EV[k];
                            result.is_pressed = 1'b1;
                            done = 1'b1;
                        end
                    end
                    else
                    begin
                        held_reported_next[k] = 1'b0;
                        hold_start_next[k]    = item.now_ms;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg   <= bevq_pkg::DEBOUNCE_RST;
            long_press_reg <= bevq_pkg::LONG_PRESS_RST;
            held_delay_reg <= bevq_pkg::HELD_DELAY_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                bevq_pkg::CFG_DEBOUNCE:   debounce_reg   <= cfg_data;
                bevq_pkg::CFG_LONG_PRESS: long_press_reg <= cfg_data;
                bevq_pkg::CFG_HELD_DELAY: held_delay_reg <= cfg_data;
                default:                  ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            edge_pending_reg  <= '0;
            held_now_reg      <= '0;
            held_reported_reg <= '0;
            for (int k = 0; k < L; k++)
            begin
                last_press_reg[k] <= '0;
                hold_start_reg[k] <= '0;
            end
            push_down_reg  <= 1'b0;
            push_start_reg <= '0;
            push_short_reg <= 1'b0;
            push_long_reg  <= 1'b0;
        end
        else if (advance)
        begin
            edge_pending_reg  <= edge_pending_next;
            held_now_reg      <= held_now_next;
            held_reported_reg <= held_reported_next;
            last_press_reg    <= last_press_next;
            hold_start_reg    <= hold_start_next;
            push_down_reg     <= push_down_next;
            push_start_reg    <= push_start_next;
            push_short_reg    <= push_short_next;
            push_long_reg     <= push_long_next;
        end
    end

endmodule

// ----- design/bevq_out_reg.sv -----
`timescale 1ns / 1ps
// bevq_out_reg: result register on the output channel
// depends on bevq_pkg

module bevq_out_reg
(
    input  logic               clk,
    input  logic               rst_n,
    input  bevq_pkg::out_ctl_t ctl,
    input  bevq_pkg::result_t  result_in,
    output logic               ready,
    output logic               out_valid,
    input  logic               out_stall,
    output bevq_pkg::result_t  result_out
);

    logic              valid_reg;
    logic              valid_next;
    bevq_pkg::result_t result_reg;

    assign ready      = !valid_reg || !out_stall;
    assign valid_next = ctl.load || (valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load && ctl.ready)
        begin
            result_reg <= result_in;
        end
    end

    assign out_valid  = valid_reg;
    assign result_out = result_reg;

endmodule

// ----- design/button_event_qualifier_top.sv -----
`timescale 1ns / 1ps
// button_event_qualifier_top: top level of the button event qualifier
// depends on bevq_pkg, bevq_in_reg, bevq_core, bevq_out_reg
// usage
//   input channel: in_valid / in_stall with opcode, now_ms, changed_mask and
//   pin_levels; a request is taken when in_valid is high and in_stall low
//   a pin-change request only updates the button state and gives no result
//   a poll request gives exactly one result on the output channel:
//   event_code, is_pressed, is_long_press under out_valid / out_stall
//   configuration: cfg_we writes cfg_data to register cfg_index
//   (0 debounce, 1 long press, 2 held delay); other indexes are dropped;
//   write only while no request is in flight
// timing
//   a poll result passes through the input register and the result register
//   one request per cycle while the result side takes it, all work in one registered pass
// reset
//   rst_n low clears all button state, both channels go empty and the
//   configuration returns to 120 / 950 / 500 ms
// stall
//   a stalled result holds in the result register; one more request waits
//   in the input register, pin changes still pass, then in_stall rises

module button_event_qualifier_top
(
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration write port
    input  logic                              cfg_we,
    input  logic [bevq_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [bevq_pkg::TIME_W-1:0]       cfg_data,
    // request channel
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              opcode,
    input  logic [bevq_pkg::TIME_W-1:0]       now_ms,
    input  logic [bevq_pkg::PIN_W-1:0]        changed_mask,
    input  logic [bevq_pkg::PIN_W-1:0]        pin_levels,
    // result channel
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [bevq_pkg::CODE_W-1:0]       event_code,
    output logic                              is_pressed,
    output logic                              is_long_press
);

    bevq_pkg::item_t    in_item;
    bevq_pkg::item_t    item;
    logic               item_valid;
    logic               advance;
    logic               out_ready;
    bevq_pkg::out_ctl_t out_ctl;
    bevq_pkg::result_t  core_result;
    bevq_pkg::result_t  result;

    // gather the request fields
    assign in_item.opcode       = opcode;
    assign in_item.now_ms       = now_ms;
    assign in_item.changed_mask = changed_mask;
    assign in_item.pin_levels   = pin_levels;

    // request register
    bevq_in_reg u_in_reg
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_item    (in_item),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    // state and single-pass update
    bevq_core u_core
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .item_valid (item_valid),
        .item       (item),
        .out_ready  (out_ready),
        .advance    (advance),
        .out_ctl    (out_ctl),
        .result     (core_result)
    );

    // result register
    bevq_out_reg u_out_reg
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (out_ctl),
        .result_in  (core_result),
        .ready      (out_ready),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .result_out (result)
    );

    assign event_code    = result.event_code;
    assign is_pressed    = result.is_pressed;
    assign is_long_press = result.is_long_press;

endmodule

// ----- design/bevq_checker.sv -----
`timescale 1ns / 1ps
// bevq_checker: port-level assertions for the button event qualifier
// depends on bevq_pkg; bound to button_event_qualifier_top

module bevq_checker
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic [bevq_pkg::CODE_W-1:0]   event_code,
    input logic                          is_pressed,
    input logic                          is_long_press
);

    // a stalled result stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(event_code)
            && $stable(is_pressed) && $stable(is_long_press))
        else $error("result changed while stalled");

    // pressed flag follows the event code
    a_pressed: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (is_pressed == (event_code != bevq_pkg::EV_NONE)))
        else $error("is_pressed does not match event_code");

    // long press only on push events
    a_long: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_long_press |-> event_code == bevq_pkg::EV_PUSH)
        else $error("long press flag on non-push event");

    // no undefined event codes
    a_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (event_code == bevq_pkg::EV_NONE || event_code == bevq_pkg::EV_PUSH
            || event_code == bevq_pkg::EV_CW || event_code == bevq_pkg::EV_CCW
            || event_code == bevq_pkg::EV_CW_HELD || event_code == bevq_pkg::EV_CCW_HELD))
        else $error("event_code out of range");

endmodule

bind button_event_qualifier_top bevq_checker u_bevq_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .event_code    (event_code),
    .is_pressed    (is_pressed),
    .is_long_press (is_long_press)
);
